FILE: rtl/core/slr_pkg.sv
`timescale 1ns / 1ps

package slr_pkg;

  localparam int AXIS_COUNT  = 6;
  localparam int VALUE_WIDTH = 16;
  localparam int EXT_WIDTH   = VALUE_WIDTH + 1;
  localparam int STEP_WIDTH  = 15;
  localparam int AGE_WIDTH   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DATA_WIDTH  = AXIS_COUNT * VALUE_WIDTH;
  localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [EXT_WIDTH-1:0]   ext_t;
  typedef logic [STEP_WIDTH-1:0]         step_t;
  typedef logic [AGE_WIDTH-1:0]          age_t;

  localparam age_t AGE_MAX = '1;

  localparam step_t MAX_STEP_RST = STEP_WIDTH'(77);
  localparam step_t CUTOFF_RST   = STEP_WIDTH'(51);
  localparam age_t  TIMEOUT_RST  = AGE_WIDTH'(40);

  typedef enum logic [CFG_IDX_W-1:0] {
    RegMaxStep = 2'd0,
    RegCutoff  = 2'd1,
    RegTimeout = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ModeCommand = 1'b0,
    ModeTick    = 1'b1
  } mode_e;

  typedef struct packed {
    logic load;
    logic tick;
    logic clear;
  } lane_ctl_t;

endpackage

FILE: rtl/core/slr_lane.sv
`timescale 1ns / 1ps

module slr_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slr_pkg::lane_ctl_t  ctl_i,
  input  slr_pkg::value_t     cmd_i,
  input  slr_pkg::step_t      max_step_i,
  input  slr_pkg::step_t      cutoff_i,
  output logic                nonzero_o,
  output slr_pkg::value_t     cur_next_o
);
  import slr_pkg::*;

  value_t tgt_q, tgt_d;
  value_t cur_q, cur_d;
  value_t tgt_eff;
  ext_t   diff, diff_mag, tgt_mag, lim, lim_neg, cut, step, sum;
  value_t slewed;

  always_comb begin
    tgt_eff  = ctl_i.clear ? '0 : tgt_q;
    diff     = ext_t'(tgt_eff) - ext_t'(cur_q);
    diff_mag = (diff < 0) ? -diff : diff;
    tgt_mag  = (tgt_eff < 0) ? -ext_t'(tgt_eff) : ext_t'(tgt_eff);
    lim      = ext_t'(max_step_i);
    lim_neg  = -lim;
    cut      = ext_t'(cutoff_i);
    if (diff > lim) begin
      step = lim;
    end else if (diff < lim_neg) begin
      step = lim_neg;
    end else begin
      step = diff;
    end
    sum    = ext_t'(cur_q) + step;
    slewed = sum[VALUE_WIDTH-1:0];
    if (diff_mag < cut) begin
      cur_next_o = (tgt_mag < cut) ? '0 : tgt_eff;
    end else begin
      cur_next_o = slewed;
    end
  end

  always_comb begin
    tgt_d = tgt_q;
    cur_d = cur_q;
    if (ctl_i.load) begin
      tgt_d = cmd_i;
    end else if (ctl_i.tick) begin
      tgt_d = tgt_eff;
      cur_d = cur_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
      cur_q <= '0;
    end else begin
      tgt_q <= tgt_d;
      cur_q <= cur_d;
    end
  end

  assign nonzero_o = (tgt_q != '0);

endmodule

FILE: rtl/core/slr_ctrl.sv
`timescale 1ns / 1ps

module slr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          mode_i,
  input  logic [slr_pkg::AXIS_COUNT-1:0] nonzero_i,
  input  slr_pkg::age_t                 timeout_i,
  output slr_pkg::lane_ctl_t            ctl_o,
  output logic                          zeroed_o
);
  import slr_pkg::*;

  age_t age_q, age_d;
  age_t age_inc;

  always_comb begin
    age_inc     = (age_q == AGE_MAX) ? age_q : age_q + AGE_WIDTH'(1);
    ctl_o.load  = accept_i && (mode_i == ModeCommand);
    ctl_o.tick  = accept_i && (mode_i == ModeTick);
    ctl_o.clear = ctl_o.tick && (age_inc > timeout_i) && (|nonzero_i);
    zeroed_o    = ctl_o.clear;
    age_d       = age_q;
    if (ctl_o.load) begin
      age_d = '0;
    end else if (ctl_o.tick) begin
      age_d = age_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else begin
      age_q <= age_d;
    end
  end

endmodule

FILE: rtl/core/six_axis_slew_limiter.sv
`timescale 1ns / 1ps
// A tick beat's result appears on the master side in the cycle after it is accepted.
// One beat per cycle unless the master stalls; six lanes and age counter update together.
// A command beat updates the targets and gives no result beat.
// Reset clears targets, the output valid flag and the age counter and loads the register
// defaults (max_step 77, cutoff 51, timeout_ticks 40); no clearing pass is needed.
module six_axis_slew_limiter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [slr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [slr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Fields from bit 0: cmd_lin_x, cmd_lin_y, cmd_lin_z, cmd_ang_x, cmd_ang_y, cmd_ang_z.
  input  logic [slr_pkg::TDATA_WIDTH-1:0]    s_axis_tdata_i,
  // Field: mode.
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // Fields from bit 0: out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z.
  output logic [slr_pkg::TDATA_WIDTH-1:0]    m_axis_tdata_o,
  // Field: zeroed_by_timeout.
  output logic                               m_axis_tuser_o
);
  import slr_pkg::*;

  step_t max_step_q, cutoff_q;
  age_t  timeout_q;

  logic                   in_accept;
  lane_ctl_t              lane_ctl;
  logic                   zeroed;
  logic [AXIS_COUNT-1:0]  nonzero;
  value_t                 cur_next [AXIS_COUNT];
  logic [TDATA_WIDTH-1:0] packed_next;

  logic                   out_valid_q;
  logic [TDATA_WIDTH-1:0] out_data_q;
  logic                   out_user_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q <= MAX_STEP_RST;
      cutoff_q   <= CUTOFF_RST;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegMaxStep: max_step_q <= cfg_data_i[STEP_WIDTH-1:0];
        RegCutoff:  cutoff_q   <= cfg_data_i[STEP_WIDTH-1:0];
        RegTimeout: timeout_q  <= cfg_data_i[AGE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The output register frees up when its beat is taken in the same cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  slr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .mode_i    (s_axis_tuser_i),
    .nonzero_i (nonzero),
    .timeout_i (timeout_q),
    .ctl_o     (lane_ctl),
    .zeroed_o  (zeroed)
  );

  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_lane
    slr_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (lane_ctl),
      .cmd_i      (s_axis_tdata_i[g*VALUE_WIDTH +: VALUE_WIDTH]),
      .max_step_i (max_step_q),
      .cutoff_i   (cutoff_q),
      .nonzero_o  (nonzero[g]),
      .cur_next_o (cur_next[g])
    );
  end

  always_comb begin
    packed_next = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      packed_next[i*VALUE_WIDTH +: VALUE_WIDTH] = cur_next[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (lane_ctl.tick) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_ctl.tick) begin
      out_data_q <= packed_next;
      out_user_q <= zeroed;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
